/* rtl/current_surge_fault_detector_defines.svh */
// assertion macros for the current surge fault detector
`ifndef CURRENT_SURGE_FAULT_DETECTOR_DEFINES_SVH
`define CURRENT_SURGE_FAULT_DETECTOR_DEFINES_SVH

`ifndef SYNTH
`define CSFD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csfd assertion failed");
`define CSFD_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("csfd forbidden condition seen");
`else
`define CSFD_ASSERT(label, clk, rst, prop)
`define CSFD_NEVER(label, clk, rst, cond)
`endif

`endif

/* rtl/csfd_pkg.sv */
// shared types, constants and functions of the current surge fault detector
package csfd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int RISE_BITS      = 10;
  localparam int LIMIT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int PHASE_BITS     = 2;
  localparam int CLASS_BITS     = 3;
  localparam int FACTOR_BITS    = 12;
  localparam int PCT_MUL_BITS   = 8;

  localparam logic [RISE_BITS:0]        PCT_BASE     = 11'd100;
  localparam logic signed [PCT_MUL_BITS-1:0] PCT_MUL = 8'sd100;

  localparam logic [RISE_BITS-1:0]  RISE_RESET  = 10'd10;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_A  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_B  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_C  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_A = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_B = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_C = 3'd5;

  localparam logic [PHASE_BITS-1:0] PHASE_A = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_B = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_C = 2'd2;

  typedef struct packed {
    logic [2:0][RISE_BITS-1:0]  rise;
    logic [2:0][LIMIT_BITS-1:0] limit;
  } csfd_cfg_t;

  typedef struct packed {
    logic                  set_end;
    logic                  record_end;
    logic [PHASE_BITS-1:0] phase;
  } csfd_tag_t;

  typedef struct packed {
    logic                  class_valid;
    logic [CLASS_BITS-1:0] fault_class;
    logic                  record_fault;
  } csfd_status_t;

  // flags bit0 A, bit1 B, bit2 C
  function automatic logic [CLASS_BITS-1:0] class_of_flags(input logic [2:0] flags);
    logic [CLASS_BITS-1:0] cls;
    case (flags)
      3'b000:  cls = 3'd0;
      3'b001:  cls = 3'd1;
      3'b010:  cls = 3'd2;
      3'b100:  cls = 3'd3;
      3'b011:  cls = 3'd4;
      3'b101:  cls = 3'd5;
      3'b110:  cls = 3'd6;
      default: cls = 3'd7;
    endcase
    return cls;
  endfunction

endpackage

/* rtl/current_surge_fault_detector.sv */
// top level of the current surge fault detector
//
// Counts rate-of-rise surges per record of phase-tagged current samples, tracks the
// record peak and reports a fault class per set. One item is accepted every clock while
// the result side keeps up. An item sits in the input register while its state update and
// result are formed combinationally. The result item is registered in the output register
// when the last item of its record leaves the input register, and is then offered on
// m_tvalid. While the output register holds a result that has not been taken, every
// item waits, including items that end no record. The one-item rate is set by the
// combinational update loop of surge count, peak and previous sample. That loop needs one
// sample-by-8-bit multiply, one sample-by-12-bit multiply and a compare. Reset needs no
// clearing pass.
module current_surge_fault_detector
  import csfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_BITS = ((COUNT_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,   // sample
  input  logic [2:0]                s_tuser,   // phase[1:0], set_end
  input  logic                      s_tlast,   // record_end
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,   // rise_count, peak_sample
  output logic [4:0]                m_tuser    // record_fault, fault_class[2:0], class_valid
);

  csfd_cfg_t    cfg;
  csfd_tag_t    in_tag, item_tag;
  csfd_status_t res_status, out_status;

  logic                   item_valid, item_take;
  logic [SAMPLE_BITS-1:0] item_sample;
  logic                   res_valid, res_free;
  logic [COUNT_BITS-1:0]  res_count, out_count;
  logic [SAMPLE_BITS-1:0] res_peak, out_peak;

  assign in_tag.phase      = s_tuser[PHASE_BITS-1:0];
  assign in_tag.set_end    = s_tuser[PHASE_BITS];
  assign in_tag.record_end = s_tlast;

  csfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csfd_in_reg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
    .in_tag      (in_tag),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item_sample (item_sample),
    .item_tag    (item_tag)
  );

  csfd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .res_free    (res_free),
    .item_take   (item_take),
    .item_sample (item_sample),
    .item_tag    (item_tag),
    .res_valid   (res_valid),
    .res_count   (res_count),
    .res_peak    (res_peak),
    .res_status  (res_status)
  );

  csfd_out_reg #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_free   (res_free),
    .res_count  (res_count),
    .res_peak   (res_peak),
    .res_status (res_status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_count  (out_count),
    .out_peak   (out_peak),
    .out_status (out_status)
  );

  always_comb begin
    m_tdata                             = '0;
    m_tdata[COUNT_BITS-1:0]             = out_count;
    m_tdata[COUNT_BITS +: SAMPLE_BITS]  = out_peak;
    m_tuser[0]                          = out_status.record_fault;
    m_tuser[3:1]                        = out_status.fault_class;
    m_tuser[4]                          = out_status.class_valid;
  end

endmodule

/* rtl/csfd_cfg_regs.sv */
// configuration registers: rise percents and count limits per phase
module csfd_cfg_regs
  import csfd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output csfd_cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise  <= {3{RISE_RESET}};
      cfg.limit <= {3{LIMIT_RESET}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RISE_A:  cfg.rise[0]  <= cfg_data[RISE_BITS-1:0];
        REG_RISE_B:  cfg.rise[1]  <= cfg_data[RISE_BITS-1:0];
        REG_RISE_C:  cfg.rise[2]  <= cfg_data[RISE_BITS-1:0];
        REG_LIMIT_A: cfg.limit[0] <= cfg_data[LIMIT_BITS-1:0];
        REG_LIMIT_B: cfg.limit[1] <= cfg_data[LIMIT_BITS-1:0];
        REG_LIMIT_C: cfg.limit[2] <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/csfd_in_reg.sv */
// input register stage holding one sample item
module csfd_in_reg
  import csfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  csfd_tag_t              in_tag,
  output logic                   item_valid,
  input  logic                   item_take,
  output logic [SAMPLE_BITS-1:0] item_sample,
  output csfd_tag_t              item_tag
);

  logic valid;

  assign in_ready    = !valid || item_take;
  assign item_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (item_take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_sample <= in_sample;
      item_tag    <= in_tag;
    end
  end

endmodule

/* rtl/csfd_core.sv */
// per-record surge count, peak tracking and phase fault flags
module csfd_core
  import csfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  csfd_cfg_t              cfg,
  input  logic                   item_valid,
  input  logic                   res_free,
  output logic                   item_take,
  input  logic [SAMPLE_BITS-1:0] item_sample,
  input  csfd_tag_t              item_tag,
  output logic                   res_valid,
  output logic [COUNT_BITS-1:0]  res_count,
  output logic [SAMPLE_BITS-1:0] res_peak,
  output csfd_status_t           res_status
);

`include "current_surge_fault_detector_defines.svh"

  localparam int LHS_BITS  = SAMPLE_BITS + PCT_MUL_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + FACTOR_BITS;
  localparam int CMP_BITS  = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  logic signed [SAMPLE_BITS-1:0] prev, prev_next;
  logic signed [SAMPLE_BITS-1:0] peak, peak_next;
  logic [COUNT_BITS-1:0]         cnt, cnt_next;
  logic                          have_prev, have_prev_next;
  logic [2:0]                    flags, flags_next;

  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [LHS_BITS-1:0]    lhs;
  logic signed [PROD_BITS-1:0]   rhs;
  logic signed [FACTOR_BITS-1:0] factor;
  logic [RISE_BITS-1:0]          rise_sel;
  logic [LIMIT_BITS-1:0]         limit_sel;
  logic [2:0]                    phase_bit;
  logic                          phase_ok;
  logic                          surge;
  logic [COUNT_BITS-1:0]         cnt_upd;
  logic signed [SAMPLE_BITS-1:0] peak_upd;
  logic                          fault;
  logic [2:0]                    flags_or;
  logic                          fire;

  assign item_take = item_valid && res_free;
  assign fire      = item_take;
  assign s         = $signed(item_sample);

  always_comb begin
    case (item_tag.phase)
      PHASE_A: begin
        rise_sel  = cfg.rise[0];
        limit_sel = cfg.limit[0];
        phase_bit = 3'b001;
        phase_ok  = 1'b1;
      end
      PHASE_B: begin
        rise_sel  = cfg.rise[1];
        limit_sel = cfg.limit[1];
        phase_bit = 3'b010;
        phase_ok  = 1'b1;
      end
      PHASE_C: begin
        rise_sel  = cfg.rise[2];
        limit_sel = cfg.limit[2];
        phase_bit = 3'b100;
        phase_ok  = 1'b1;
      end
      default: begin
        rise_sel  = '0;
        limit_sel = '0;
        phase_bit = 3'b000;
        phase_ok  = 1'b0;
      end
    endcase
  end

  // sample*100 against previous*(100+rise)
  assign factor = $signed({1'b0, PCT_BASE + {1'b0, rise_sel}});
  assign lhs    = s * PCT_MUL;
  assign rhs    = prev * factor;
  assign surge  = have_prev && phase_ok && (PROD_BITS'(lhs) > rhs);

  assign cnt_upd  = (surge && (cnt != '1)) ? cnt + 1'b1 : cnt;
  assign peak_upd = (!have_prev || (s > peak)) ? s : peak;
  assign fault    = phase_ok && (CMP_BITS'(cnt_upd) >= CMP_BITS'(limit_sel));
  assign flags_or = flags | (fault ? phase_bit : 3'b000);

  always_comb begin
    prev_next      = prev;
    peak_next      = peak;
    cnt_next       = cnt;
    have_prev_next = have_prev;
    flags_next     = flags;
    if (fire) begin
      if (item_tag.record_end) begin
        prev_next      = '0;
        peak_next      = '0;
        cnt_next       = '0;
        have_prev_next = 1'b0;
        flags_next     = item_tag.set_end ? 3'b000 : flags_or;
      end else begin
        prev_next      = s;
        peak_next      = peak_upd;
        cnt_next       = cnt_upd;
        have_prev_next = 1'b1;
      end
    end
  end

  always_comb begin
    res_valid               = fire && item_tag.record_end;
    res_count               = cnt_upd;
    res_peak                = peak_upd;
    res_status.record_fault = fault;
    res_status.fault_class  = item_tag.set_end ? class_of_flags(flags_or) : '0;
    res_status.class_valid  = item_tag.set_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      peak      <= '0;
      cnt       <= '0;
      have_prev <= 1'b0;
      flags     <= 3'b000;
    end else begin
      prev      <= prev_next;
      peak      <= peak_next;
      cnt       <= cnt_next;
      have_prev <= have_prev_next;
      flags     <= flags_next;
    end
  end

  `CSFD_ASSERT(a_record_end_restarts, clk, rst,
    (fire && item_tag.record_end) |=> (!have_prev && cnt == '0))
  `CSFD_ASSERT(a_sample_sets_previous, clk, rst,
    (fire && !item_tag.record_end) |=> have_prev)
  `CSFD_ASSERT(a_count_monotonic, clk, rst,
    (fire && !item_tag.record_end) |=> (cnt >= $past(cnt)))
  `CSFD_ASSERT(a_set_end_clears_flags, clk, rst,
    (fire && item_tag.record_end && item_tag.set_end) |=> (flags == 3'b000))
  `CSFD_NEVER(a_no_result_when_full, clk, rst, res_valid && !res_free)

endmodule

/* rtl/csfd_out_reg.sv */
// output register holding one result item
module csfd_out_reg
  import csfd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  output logic                   res_free,
  input  logic [COUNT_BITS-1:0]  res_count,
  input  logic [SAMPLE_BITS-1:0] res_peak,
  input  csfd_status_t           res_status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_BITS-1:0]  out_count,
  output logic [SAMPLE_BITS-1:0] out_peak,
  output csfd_status_t           out_status
);

  logic valid;

  assign res_free  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_valid) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_count  <= res_count;
      out_peak   <= res_peak;
      out_status <= res_status;
    end
  end

endmodule
